@@ rtl/core/bdq_pkg.sv @@
// bdq_pkg: shared types and constants for the bounded array deque
`timescale 1ns / 1ps
package bdq_pkg;

   localparam int DEPTH  = 64;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = IDX_W + 1;
   localparam int DATA_W = 32;

   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_PEEK       = 3'd4;
   localparam logic [2:0] CMD_DUMP       = 3'd5;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_OVF   = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic [2:0]               command;
      logic signed [DATA_W-1:0] push_value;
   } bdq_req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] back_value;
      logic [CNT_W-1:0]         element_count;
      logic                     is_vacant;
      logic signed [DATA_W-1:0] dump_value;
      logic                     last;
   } bdq_rsp_type;

endpackage

@@ rtl/core/bounded_array_deque.sv @@
// bounded_array_deque: linear array deque with push, pop, peek and dump commands
//
//   channel  | signals                         | direction
//   ---------+---------------------------------+----------
//   request  | req_valid, req_ready, req_payload | in
//   response | rsp_valid, rsp_ready, rsp_payload | out
//
// Each command steps through execute, front read, back read, back capture and emit;
// a non-empty dump swaps emit for a read and an output step per element. The single
// read port of the storage sets this: front, back and every dumped word are read one
// after another. The next request can be accepted while the last response is pending.
// Reset clears head, tail, vacant flag and sequencer; dump pointer and storage are not cleared.
// A stalled response only holds the sequencer at its output step.
`timescale 1ns / 1ps
module bounded_array_deque (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bdq_pkg::bdq_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bdq_pkg::bdq_rsp_type rsp_payload
);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_EXEC = 8'b0000_0010,
      S_RDF  = 8'b0000_0100,
      S_RDB  = 8'b0000_1000,
      S_CAPB = 8'b0001_0000,
      S_EMIT = 8'b0010_0000,
      S_DRD  = 8'b0100_0000,
      S_DOUT = 8'b1000_0000
   } state_type;

   localparam logic [bdq_pkg::IDX_W-1:0] IDX_TOP = bdq_pkg::IDX_W'(bdq_pkg::DEPTH - 1);
   localparam logic [bdq_pkg::IDX_W-1:0] IDX_ZERO = '0;

   state_type state_ff, state_in;
   logic [bdq_pkg::IDX_W-1:0] head_ff, head_in;
   logic [bdq_pkg::IDX_W-1:0] tail_ff, tail_in;
   logic vacant_ff, vacant_in;
   logic [bdq_pkg::IDX_W-1:0] dptr_ff, dptr_in;
   logic [2:0] cmd_ff, cmd_in;
   logic signed [bdq_pkg::DATA_W-1:0] val_ff, val_in;
   logic [1:0] status_ff, status_in;
   logic signed [bdq_pkg::DATA_W-1:0] front_ff, front_in;
   logic signed [bdq_pkg::DATA_W-1:0] back_ff, back_in;
   logic rsp_valid_ff, rsp_valid_in;
   bdq_pkg::bdq_rsp_type rsp_ff, rsp_in;

   logic wr_en;
   logic [bdq_pkg::IDX_W-1:0] wr_addr;
   logic rd_en;
   logic [bdq_pkg::IDX_W-1:0] rd_addr;
   logic signed [bdq_pkg::DATA_W-1:0] rd_data;
   logic slot_free;
   logic [bdq_pkg::CNT_W-1:0] count;

   bdq_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (val_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign count = vacant_ff ? '0
                  : ({1'b0, tail_ff} - {1'b0, head_ff} + bdq_pkg::CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      vacant_in    = vacant_ff;
      dptr_in      = dptr_ff;
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      status_in    = status_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      wr_addr      = IDX_ZERO;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      req_ready    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = req_payload.command;
               val_in   = req_payload.push_value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = bdq_pkg::STAT_OK;
            state_in  = S_RDF;
            unique case (cmd_ff)
               bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
                  if (vacant_ff) begin
                     // first element always lands at index 0
                     vacant_in = 1'b0;
                     head_in   = IDX_ZERO;
                     tail_in   = IDX_ZERO;
                     wr_en     = 1'b1;
                     wr_addr   = IDX_ZERO;
                  end else if (cmd_ff == bdq_pkg::CMD_PUSH_FRONT) begin
                     if (head_ff == IDX_ZERO) begin
                        status_in = bdq_pkg::STAT_OVF;
                     end else begin
                        head_in = head_ff - 1'b1;
                        wr_en   = 1'b1;
                        wr_addr = head_ff - 1'b1;
                     end
                  end else begin
                     if (tail_ff == IDX_TOP) begin
                        status_in = bdq_pkg::STAT_OVF;
                     end else begin
                        tail_in = tail_ff + 1'b1;
                        wr_en   = 1'b1;
                        wr_addr = tail_ff + 1'b1;
                     end
                  end
               end
               bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK: begin
                  if (vacant_ff) begin
                     status_in = bdq_pkg::STAT_EMPTY;
                  end else if (head_ff >= tail_ff) begin
                     vacant_in = 1'b1;
                     head_in   = IDX_ZERO;
                     tail_in   = IDX_ZERO;
                  end else if (cmd_ff == bdq_pkg::CMD_POP_FRONT) begin
                     head_in = head_ff + 1'b1;
                  end else begin
                     tail_in = tail_ff - 1'b1;
                  end
               end
               default: begin
                  // peek, dump and the unused codes
                  if (vacant_ff) begin
                     status_in = bdq_pkg::STAT_EMPTY;
                  end
               end
            endcase
         end
         S_RDF: begin
            rd_en    = 1'b1;
            rd_addr  = head_ff;
            state_in = S_RDB;
         end
         S_RDB: begin
            rd_en    = 1'b1;
            rd_addr  = tail_ff;
            front_in = vacant_ff ? '0 : rd_data;
            state_in = S_CAPB;
         end
         S_CAPB: begin
            back_in = vacant_ff ? '0 : rd_data;
            dptr_in = head_ff;
            if (cmd_ff == bdq_pkg::CMD_DUMP && !vacant_ff) begin
               state_in = S_DRD;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_in.status        = status_ff;
               rsp_in.front_value   = front_ff;
               rsp_in.back_value    = back_ff;
               rsp_in.element_count = count;
               rsp_in.is_vacant     = vacant_ff;
               rsp_in.dump_value    = '0;
               rsp_in.last          = 1'b1;
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         S_DRD: begin
            rd_en    = 1'b1;
            rd_addr  = dptr_ff;
            state_in = S_DOUT;
         end
         S_DOUT: begin
            if (slot_free) begin
               rsp_in.status        = bdq_pkg::STAT_OK;
               rsp_in.front_value   = front_ff;
               rsp_in.back_value    = back_ff;
               rsp_in.element_count = count;
               rsp_in.is_vacant     = 1'b0;
               rsp_in.dump_value    = rd_data;
               rsp_in.last          = (dptr_ff == tail_ff);
               rsp_valid_in         = 1'b1;
               dptr_in              = dptr_ff + 1'b1;
               state_in             = (dptr_ff == tail_ff) ? S_IDLE : S_DRD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         vacant_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         vacant_ff    <= vacant_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dptr_ff   <= dptr_in;
      cmd_ff    <= cmd_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      front_ff  <= front_in;
      back_ff   <= back_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/core/bdq_store.sv @@
// bdq_store: element storage, one write port and one registered read port
`timescale 1ns / 1ps
module bdq_store (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [bdq_pkg::IDX_W-1:0]        wr_addr,
   input  logic signed [bdq_pkg::DATA_W-1:0] wr_data,
   input  logic                             rd_en,
   input  logic [bdq_pkg::IDX_W-1:0]        rd_addr,
   output logic signed [bdq_pkg::DATA_W-1:0] rd_data
);

   logic signed [bdq_pkg::DATA_W-1:0] mem [bdq_pkg::DEPTH];
   logic signed [bdq_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
